FILE: rtl/cpa_pkg.sv
// shared constants, codes and interface structs of the contiguous page allocator
// no dependencies; imported by every rtl module of the block
package cpa_pkg;

   localparam int NUM_PAGES = 256;
   localparam int PAGE_BITS = 12;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 21;
   localparam int STATUS_W = 2;
   localparam int RP_W     = 9;

   localparam int IDX_W   = $clog2(NUM_PAGES);
   localparam int CNT_W   = $clog2(NUM_PAGES + 1);
   localparam int LIM_W   = (CNT_W > RP_W) ? CNT_W : RP_W;
   localparam int PG_W    = SIZE_W - PAGE_BITS + 1;
   localparam int FIRST_W = ADDR_W - PAGE_BITS;
   localparam int SUM_W   = FIRST_W + 1;

   localparam int SER_CNT_W = $clog2(ADDR_W + 1);

   localparam int REQ_TDATA_W = ((SIZE_W + ADDR_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_PAGES = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_RANGE   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_ADD,
      ST_FREE_SUB,
      ST_FREE_CHK,
      ST_FREE_CLR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic             wr_bit;
      logic [IDX_W-1:0] addr;
   } map_cmd_type;

   typedef struct packed {
      logic start;
      logic sub;
   } ser_cmd_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] result;
   } ser_stat_type;

endpackage

FILE: rtl/cpa_page_map.sv
// page usage map: one used bit per page, single port, registered read
// depends on cpa_pkg
module cpa_page_map (
   input  logic               clock,
   input  cpa_pkg::map_cmd_type cmd,
   output logic               rd_bit
);
   import cpa_pkg::*;

   logic mem [NUM_PAGES];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_bit;
      end
      if (cmd.rd_en) begin
         rd_bit_ff <= mem[cmd.addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

FILE: rtl/cpa_serial_addsub.sv
// bit-serial adder / subtractor, lsb first, one bit per cycle
// depends on cpa_pkg
module cpa_serial_addsub (
   input  logic                        clock,
   input  logic                        reset,
   input  cpa_pkg::ser_cmd_type        cmd,
   input  logic [cpa_pkg::ADDR_W-1:0]  a,
   input  logic [cpa_pkg::ADDR_W-1:0]  b,
   output cpa_pkg::ser_stat_type       stat
);
   import cpa_pkg::*;

   logic [ADDR_W-1:0]    a_sh_ff, a_sh_in;
   logic [ADDR_W-1:0]    b_sh_ff, b_sh_in;
   logic [ADDR_W-1:0]    sum_sh_ff, sum_sh_in;
   logic                 carry_ff, carry_in;
   logic                 sub_ff, sub_in;
   logic [SER_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic bit_a, bit_b, sum_bit, carry_out;

   always_comb begin
      bit_a     = a_sh_ff[0];
      bit_b     = b_sh_ff[0] ^ sub_ff;
      sum_bit   = bit_a ^ bit_b ^ carry_ff;
      carry_out = (bit_a & bit_b) | (bit_a & carry_ff) | (bit_b & carry_ff);
   end

   always_comb begin
      a_sh_in   = a_sh_ff;
      b_sh_in   = b_sh_ff;
      sum_sh_in = sum_sh_ff;
      carry_in  = carry_ff;
      sub_in    = sub_ff;
      cnt_in    = cnt_ff;
      done_in   = (cnt_ff == SER_CNT_W'(1)) && !cmd.start;
      if (cmd.start) begin
         a_sh_in  = a;
         b_sh_in  = b;
         carry_in = cmd.sub;
         sub_in   = cmd.sub;
         cnt_in   = SER_CNT_W'(ADDR_W);
      end else if (cnt_ff != '0) begin
         a_sh_in   = {1'b0, a_sh_ff[ADDR_W-1:1]};
         b_sh_in   = {1'b0, b_sh_ff[ADDR_W-1:1]};
         sum_sh_in = {sum_bit, sum_sh_ff[ADDR_W-1:1]};
         carry_in  = carry_out;
         cnt_in    = cnt_ff - SER_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_sh_ff   <= a_sh_in;
      b_sh_ff   <= b_sh_in;
      sum_sh_ff <= sum_sh_in;
      carry_ff  <= carry_in;
      sub_ff    <= sub_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = sum_sh_ff;

endmodule

FILE: rtl/contiguous_page_allocator_unit.sv
// first-fit page allocator over a one-bit-per-page usage map; uses cpa_pkg,
// cpa_page_map and cpa_serial_addsub
// allocate: map scan, run mark, serial add of base and run offset; no space: ends after the scan
// free: serial subtract of base, range check, run clear; out of range: ends after the range check;
// zero size: goes straight to the response; one transaction at a time
// synchronous reset; afterwards a pass over all 256 map entries clears the map with req_tready low
module contiguous_page_allocator_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cpa_pkg::REQ_TDATA_W-1:0]   req_tdata,   // size_bytes[20:0], addr_in[52:21]
   input  logic                              req_tuser,   // op: 0 allocate, 1 free
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cpa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // addr_out[31:0], status[33:32]
   // register write port
   input  logic                              csr_we,
   input  logic [cpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpa_pkg::ADDR_W-1:0]        csr_wdata
);
   import cpa_pkg::*;

   // config registers
   logic [ADDR_W-1:0] region_base_ff;
   logic [RP_W-1:0]   region_pages_ff;

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [LIM_W-1:0]  ptr_ff, ptr_in;        // scan / mark / clear pointer
   logic [LIM_W-1:0]  end_ff, end_in;        // last page of run to write
   logic [LIM_W-1:0]  start_ff, start_in;    // first page of granted run
   logic [PG_W-1:0]   run_ff, run_in;        // free pages seen in a row
   logic              chk_ff, chk_in;        // map read in flight
   logic [LIM_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [PG_W-1:0]   pages_ff, pages_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   // submodule links
   map_cmd_type       map_cmd;
   logic              map_rdata;
   ser_cmd_type       ser_cmd;
   ser_stat_type      ser_stat;
   logic [ADDR_W-1:0] ser_a, ser_b;

   // request fields
   logic [SIZE_W-1:0] req_size;
   logic [ADDR_W-1:0] req_addr;
   logic              req_size_zero;
   logic [PG_W-1:0]   req_pages;

   // decode helpers
   logic [LIM_W-1:0]   lim;
   logic               scan_issue, scan_hit, scan_miss, mark_last, rsp_slot_free;
   logic [SUM_W-1:0]   scan_start_w;
   logic [FIRST_W-1:0] free_first;
   logic [SUM_W-1:0]   free_sum, free_end_w;
   logic               range_bad;

   assign req_size      = req_tdata[SIZE_W-1:0];
   assign req_addr      = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
   assign req_size_zero = (req_size == '0);
   // round up to whole pages
   assign req_pages     = PG_W'(req_size[SIZE_W-1:PAGE_BITS])
                        + PG_W'(req_size[PAGE_BITS-1:0] != '0);

   // usable pages: smaller of register and map depth
   assign lim = (LIM_W'(region_pages_ff) < LIM_W'(NUM_PAGES)) ?
                LIM_W'(region_pages_ff) : LIM_W'(NUM_PAGES);

   assign scan_issue   = (ptr_ff < lim);
   assign scan_hit     = chk_ff && !map_rdata && ((run_ff + PG_W'(1)) == pages_ff);
   assign scan_miss    = !chk_ff && !scan_issue;
   assign scan_start_w = SUM_W'(chk_idx_ff) + SUM_W'(1) - SUM_W'(pages_ff);
   assign mark_last    = (ptr_ff == end_ff);

   // free: first page from the serial difference, bound check against usable pages
   assign free_first = ser_stat.result[ADDR_W-1:PAGE_BITS];
   assign free_sum   = SUM_W'(free_first) + SUM_W'(pages_ff);
   assign free_end_w = free_sum - SUM_W'(1);
   assign range_bad  = (free_sum > SUM_W'(lim));

   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;

   // serial unit operands: addr_in - base on free, base + run offset on allocate
   assign ser_a = (state_ff == ST_IDLE) ? req_addr : region_base_ff;
   assign ser_b = (state_ff == ST_IDLE) ? region_base_ff
                                        : (ADDR_W'(start_ff) << PAGE_BITS);

   cpa_page_map u_map (
      .clock  (clock),
      .cmd    (map_cmd),
      .rd_bit (map_rdata)
   );

   cpa_serial_addsub u_ser (
      .clock (clock),
      .reset (reset),
      .cmd   (ser_cmd),
      .a     (ser_a),
      .b     (ser_b),
      .stat  (ser_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == LIM_W'(NUM_PAGES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_size_zero)            state_in = ST_DONE;
               else if (req_tuser == OP_ALLOC) state_in = ST_SCAN;
               else                          state_in = ST_FREE_SUB;
            end
         end
         ST_SCAN: begin
            if (scan_hit)       state_in = ST_MARK;
            else if (scan_miss) state_in = ST_DONE;
         end
         ST_MARK: begin
            if (mark_last) state_in = ST_ADD;
         end
         ST_ADD: begin
            if (ser_stat.done) state_in = ST_DONE;
         end
         ST_FREE_SUB: begin
            if (ser_stat.done) state_in = ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            if (range_bad) state_in = ST_DONE;
            else           state_in = ST_FREE_CLR;
         end
         ST_FREE_CLR: begin
            if (mark_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // datapath and submodule controls
   always_comb begin
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      pages_in      = pages_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      map_cmd       = '0;
      ser_cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            // sweep every map entry to free
            map_cmd.wr_en  = 1'b1;
            map_cmd.wr_bit = 1'b0;
            map_cmd.addr   = ptr_ff[IDX_W-1:0];
            ptr_in         = ptr_ff + LIM_W'(1);
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               pages_in = req_pages;
               if (req_size_zero) begin
                  res_addr_in   = '0;
                  res_status_in = STAT_RANGE;
               end else if (req_tuser == OP_ALLOC) begin
                  ptr_in = '0;
                  run_in = '0;
                  chk_in = 1'b0;
               end else begin
                  ser_cmd.start = 1'b1;
                  ser_cmd.sub   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // read one page per cycle, judge it in the cycle after the read
            if (chk_ff) begin
               if (map_rdata) run_in = '0;
               else           run_in = run_ff + PG_W'(1);
            end
            if (scan_hit) begin
               start_in = scan_start_w[LIM_W-1:0];
               ptr_in   = scan_start_w[LIM_W-1:0];
               end_in   = chk_idx_ff;
               chk_in   = 1'b0;
            end else if (scan_issue) begin
               map_cmd.rd_en = 1'b1;
               map_cmd.addr  = ptr_ff[IDX_W-1:0];
               chk_in        = 1'b1;
               chk_idx_in    = ptr_ff;
               ptr_in        = ptr_ff + LIM_W'(1);
            end else begin
               chk_in = 1'b0;
               if (scan_miss) begin
                  res_addr_in   = '0;
                  res_status_in = STAT_NOSPACE;
               end
            end
         end
         ST_MARK: begin
            map_cmd.wr_en  = 1'b1;
            map_cmd.wr_bit = 1'b1;
            map_cmd.addr   = ptr_ff[IDX_W-1:0];
            ptr_in         = ptr_ff + LIM_W'(1);
            if (mark_last) begin
               ser_cmd.start = 1'b1;
               ser_cmd.sub   = 1'b0;
            end
         end
         ST_ADD: begin
            if (ser_stat.done) begin
               res_addr_in   = ser_stat.result;
               res_status_in = STAT_OK;
            end
         end
         ST_FREE_SUB: begin
            // wait for addr_in - region_base
         end
         ST_FREE_CHK: begin
            if (range_bad) begin
               res_addr_in   = '0;
               res_status_in = STAT_RANGE;
            end else begin
               ptr_in = free_first[LIM_W-1:0];
               end_in = free_end_w[LIM_W-1:0];
            end
         end
         ST_FREE_CLR: begin
            map_cmd.wr_en  = 1'b1;
            map_cmd.wr_bit = 1'b0;
            map_cmd.addr   = ptr_ff[IDX_W-1:0];
            ptr_in         = ptr_ff + LIM_W'(1);
            if (mark_last) begin
               res_addr_in   = '0;
               res_status_in = STAT_OK;
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         ptr_ff          <= '0;
         chk_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         region_base_ff  <= '0;
         region_pages_ff <= RP_W'(256);
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_REGION_BASE:  region_base_ff  <= csr_wdata;
               REG_REGION_PAGES: region_pages_ff <= csr_wdata[RP_W-1:0];
               default: begin
               end
            endcase
         end
      end
      end_ff        <= end_in;
      start_ff      <= start_in;
      run_ff        <= run_in;
      chk_idx_ff    <= chk_idx_in;
      pages_ff      <= pages_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_status_ff, rsp_addr_ff});

   // a run under count never reaches the requested length while scanning
   a_run_below_pages: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (run_ff < pages_ff))
      else $error("run counter reached page count inside scan");

   // a new response only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done state");

   // mark and free writes stay inside the usable pages
   a_write_in_region: assert property (@(posedge clock) disable iff (reset)
      (map_cmd.wr_en && (state_ff != ST_CLEAR)) |-> (ptr_ff < lim))
      else $error("map write beyond usable pages");

   // serial unit finishes only where its result is consumed
   a_ser_done_state: assert property (@(posedge clock) disable iff (reset)
      ser_stat.done |-> ((state_ff == ST_ADD) || (state_ff == ST_FREE_SUB)))
      else $error("serial result arrived in unexpected state");

endmodule
